// ----- src/bsc_pkg.sv -----
// Shared types and constants for the banker's safety check block.
`timescale 1ns / 1ps
package bsc_pkg;

	localparam int NUM_RES    = 3;
	localparam int FIELD_W    = 8;
	localparam int PID_W      = 3;
	localparam int MAX_OUT    = 8;
	localparam int OUT_IDX_W  = 3;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_ADDR_W-1:0] REG_AVAIL_R0 = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_AVAIL_R1 = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_AVAIL_R2 = 2'd2;

	typedef struct packed {
		logic [FIELD_W-1:0] alloc_r0;
		logic [FIELD_W-1:0] alloc_r1;
		logic [FIELD_W-1:0] alloc_r2;
		logic [FIELD_W-1:0] max_r0;
		logic [FIELD_W-1:0] max_r1;
		logic [FIELD_W-1:0] max_r2;
		logic               last_row;
	} row_t;

	typedef struct packed {
		logic [PID_W-1:0] proc_id;
		logic             entry_valid;
		logic             safe;
		logic             last_result;
	} result_t;

	typedef struct packed {
		logic load;
		logic seed;
		logic step;
		logic emit;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic take;
		logic last_proc;
		logic emit_last;
	} status_t;

endpackage

// ----- src/bsc_ctrl.sv -----
// Controller state machine: row loading, the safety walk and result sequencing.
`timescale 1ns / 1ps
module bsc_ctrl import bsc_pkg::*; #(
	parameter int PROCESSES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          last_row,
	input  status_t                       status,
	output logic                          busy,
	output cmd_t                          cmd,
	output logic [$clog2(PROCESSES)-1:0]  proc_idx,
	output logic [OUT_IDX_W-1:0]          emit_idx,
	output logic                          result_valid
);

	localparam int IDX_W = $clog2(PROCESSES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_EMIT
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     proc_idx_q;
	logic [IDX_W-1:0]     pass_q;
	logic                 progress_q;
	logic [OUT_IDX_W-1:0] emit_idx_q;
	logic                 result_valid_q;
	logic                 accept;

	assign accept       = start && (state_q == S_IDLE);
	assign busy         = (state_q != S_IDLE);
	assign proc_idx     = proc_idx_q;
	assign emit_idx     = emit_idx_q;
	assign result_valid = result_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.load  = accept;
		cmd.seed  = accept && last_row;
		cmd.step  = (state_q == S_WALK);
		cmd.emit  = (state_q == S_EMIT);
		cmd.clear = (state_q == S_EMIT) && status.emit_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			proc_idx_q     <= '0;
			pass_q         <= '0;
			progress_q     <= 1'b0;
			emit_idx_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (state_q == S_EMIT);
			case (state_q)
				S_IDLE: begin
					if (accept && last_row) begin
						state_q    <= S_WALK;
						proc_idx_q <= '0;
						pass_q     <= '0;
						progress_q <= 1'b0;
					end
				end
				S_WALK: begin
					if (status.last_proc) begin
						// A pass that finished nothing means no later pass can either.
						if (pass_q == IDX_W'(PROCESSES - 1) || !(progress_q || status.take)) begin
							state_q    <= S_EMIT;
							emit_idx_q <= '0;
						end else begin
							pass_q     <= pass_q + 1'b1;
							proc_idx_q <= '0;
							progress_q <= 1'b0;
						end
					end else begin
						proc_idx_q <= proc_idx_q + 1'b1;
						progress_q <= progress_q || status.take;
					end
				end
				S_EMIT: begin
					emit_idx_q <= emit_idx_q + 1'b1;
					if (status.emit_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/bsc_datapath.sv -----
// Datapath: row stores, work vector, fit test, finish order and result register.
`timescale 1ns / 1ps
module bsc_datapath import bsc_pkg::*; #(
	parameter int PROCESSES = 8,
	parameter int UNIT_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	input  row_t                         row,
	input  logic [$clog2(PROCESSES)-1:0] proc_idx,
	input  logic [OUT_IDX_W-1:0]         emit_idx,
	input  logic                         wr_en,
	input  logic [CFG_ADDR_W-1:0]        wr_addr,
	input  logic [CFG_DATA_W-1:0]        wr_data,
	output status_t                      status,
	output result_t                      result
);

	localparam int U_W         = (UNIT_BITS < FIELD_W) ? UNIT_BITS : FIELD_W;
	localparam int IDX_W       = $clog2(PROCESSES);
	localparam int CNT_W       = $clog2(PROCESSES + 1);
	localparam int WORK_W      = U_W + $clog2(PROCESSES + 1);
	localparam int ORDER_DEPTH = (PROCESSES < MAX_OUT) ? PROCESSES : MAX_OUT;
	localparam int ORD_W       = $clog2(ORDER_DEPTH);
	localparam int CMP_W       = (CNT_W > OUT_IDX_W + 1) ? CNT_W : OUT_IDX_W + 1;

	logic [U_W-1:0]    avail_q [NUM_RES];
	logic [U_W-1:0]    alloc_q [PROCESSES][NUM_RES];
	logic [U_W-1:0]    need_q  [PROCESSES][NUM_RES];
	logic [WORK_W-1:0] work_q  [NUM_RES];
	logic [PROCESSES-1:0] fin_q;
	logic [CNT_W-1:0]  rows_q;
	logic [CNT_W-1:0]  count_q;
	logic [PID_W-1:0]  order_q [ORDER_DEPTH];
	result_t           result_q;

	logic [U_W-1:0]    row_alloc [NUM_RES];
	logic [U_W-1:0]    row_max   [NUM_RES];
	logic [U_W-1:0]    row_need  [NUM_RES];
	logic              room;
	logic              fits;
	logic              take;
	logic [CMP_W-1:0]  next_pos;
	logic              emit_last;
	result_t           result_d;

	always_comb begin
		row_alloc[0] = row.alloc_r0[U_W-1:0];
		row_alloc[1] = row.alloc_r1[U_W-1:0];
		row_alloc[2] = row.alloc_r2[U_W-1:0];
		row_max[0]   = row.max_r0[U_W-1:0];
		row_max[1]   = row.max_r1[U_W-1:0];
		row_max[2]   = row.max_r2[U_W-1:0];
		for (int r = 0; r < NUM_RES; r++) begin
			// A claim below the holding means no further need.
			row_need[r] = (row_max[r] > row_alloc[r]) ? (row_max[r] - row_alloc[r]) : '0;
		end
	end

	assign room = (rows_q < CNT_W'(PROCESSES));

	always_comb begin
		fits = 1'b1;
		for (int r = 0; r < NUM_RES; r++) begin
			if (WORK_W'(need_q[proc_idx][r]) > work_q[r]) begin
				fits = 1'b0;
			end
		end
	end

	assign take = cmd.step && !fin_q[proc_idx] && fits;

	assign next_pos  = CMP_W'(emit_idx) + 1'b1;
	assign emit_last = (count_q == '0) || (next_pos == CMP_W'(count_q)) ||
		(emit_idx == OUT_IDX_W'(MAX_OUT - 1));

	assign status.take      = !fin_q[proc_idx] && fits;
	assign status.last_proc = ((CNT_W'(proc_idx) + 1'b1) == rows_q);
	assign status.emit_last = emit_last;

	always_comb begin
		result_d = '0;
		if (count_q == '0) begin
			result_d.last_result = 1'b1;
		end else begin
			result_d.proc_id     = order_q[emit_idx[ORD_W-1:0]];
			result_d.entry_valid = 1'b1;
			result_d.safe        = (count_q == rows_q);
			result_d.last_result = emit_last;
		end
	end

	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_RES; r++) begin
				avail_q[r] <= '0;
				work_q[r]  <= '0;
			end
			fin_q   <= '0;
			rows_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				case (wr_addr)
					REG_AVAIL_R0: avail_q[0] <= wr_data[U_W-1:0];
					REG_AVAIL_R1: avail_q[1] <= wr_data[U_W-1:0];
					REG_AVAIL_R2: avail_q[2] <= wr_data[U_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load && room) begin
				rows_q <= rows_q + 1'b1;
			end
			if (cmd.seed) begin
				for (int r = 0; r < NUM_RES; r++) begin
					work_q[r] <= WORK_W'(avail_q[r]);
				end
				fin_q   <= '0;
				count_q <= '0;
			end
			if (take) begin
				for (int r = 0; r < NUM_RES; r++) begin
					work_q[r] <= work_q[r] + WORK_W'(alloc_q[proc_idx][r]);
				end
				fin_q[proc_idx] <= 1'b1;
				count_q         <= count_q + 1'b1;
			end
			if (cmd.clear) begin
				for (int r = 0; r < NUM_RES; r++) begin
					work_q[r] <= '0;
				end
				fin_q  <= '0;
				rows_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			for (int r = 0; r < NUM_RES; r++) begin
				alloc_q[rows_q[IDX_W-1:0]][r] <= row_alloc[r];
				need_q[rows_q[IDX_W-1:0]][r]  <= row_need[r];
			end
		end
		if (take && (count_q < CNT_W'(ORDER_DEPTH))) begin
			order_q[count_q[ORD_W-1:0]] <= PID_W'(proc_idx);
		end
		if (cmd.emit) begin
			result_q <= result_d;
		end
	end

endmodule

// ----- src/bankers_safety_check.sv -----
// Top level of the banker's algorithm safety check.
//
//   Channel   Direction  Handshake                      Payload
//   rows      in         start high while busy is low   row      (row_t)
//   results   out        result_valid, one cycle each   result   (result_t)
//   config    in         wr_en, no wait                 wr_addr, wr_data
//
// The block can take a row every cycle while busy is low. The row marked last
// seeds the work vector and starts the walk: one process is examined per cycle
// by the single fit-test and add unit, pass after pass. The walk ends early
// after a pass that finished nothing. Results then leave one per cycle (one to
// eight of them), and busy drops with the cycle that shows the final one.
// Reset clears the available registers, the table and the walk; the row stores
// need no clearing. The receiver cannot stall, so results are never held.
`timescale 1ns / 1ps
module bankers_safety_check import bsc_pkg::*; #(
	parameter int PROCESSES = 8,
	parameter int UNIT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  row_t                  row,
	output logic                  busy,
	output logic                  result_valid,
	output result_t               result,
	input  logic                  wr_en,
	input  logic [CFG_ADDR_W-1:0] wr_addr,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	// Command and status between the sequencer and the datapath.
	cmd_t                         cmd;
	status_t                      status;
	logic [$clog2(PROCESSES)-1:0] proc_idx;
	logic [OUT_IDX_W-1:0]         emit_idx;

	// The controller decides when a row transfer completes and walks the
	// process index; it also owns the result strobe.
	bsc_ctrl #(
		.PROCESSES(PROCESSES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_row    (row.last_row),
		.status      (status),
		.busy        (busy),
		.cmd         (cmd),
		.proc_idx    (proc_idx),
		.emit_idx    (emit_idx),
		.result_valid(result_valid)
	);

	// The datapath holds the rows, the work vector and the finish order, and
	// registers each result in the same cycle the controller raises the strobe.
	bsc_datapath #(
		.PROCESSES(PROCESSES),
		.UNIT_BITS(UNIT_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.row     (row),
		.proc_idx(proc_idx),
		.emit_idx(emit_idx),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.status  (status),
		.result  (result)
	);

endmodule

// ----- src/bsc_checker.sv -----
// Port-level checks for the banker's safety check, bound to the top level.
`timescale 1ns / 1ps
module bsc_checker import bsc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  row_t                  row,
	input  logic                  busy,
	input  logic                  result_valid,
	input  result_t               result
);

	a_last_row_starts_check: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && row.last_row) |=> busy)
		else $error("check did not start after the last row");

	a_results_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last_result) |-> (busy ##1 result_valid))
		else $error("result sequence broken before its final transfer");

	a_idle_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_result) |-> !busy)
		else $error("block still busy after the final result");

	a_empty_result_form: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.entry_valid) |->
			(result.last_result && !result.safe && (result.proc_id == '0)))
		else $error("malformed result for a check where nothing finished");

endmodule

bind bankers_safety_check bsc_checker u_bsc_checker (.*);

// ----- bench/tb_bankers_safety_check.sv -----
// Self-checking testbench for the banker's safety check block.
`timescale 1ns / 1ps
module tb_bankers_safety_check;
	import bsc_pkg::*;

	localparam int PROCESSES = 8;
	localparam int UNIT_BITS = 8;
	// The drain spans the longest walk, PROCESSES passes over PROCESSES rows,
	// and then up to MAX_OUT results, with a margin for the pipeline.
	localparam int DRAIN_CYCLES = PROCESSES * PROCESSES + MAX_OUT + 8;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ROWS = 360;
	localparam int PHASE_ROWS = 30;
	localparam int TIMEOUT_CYCLES = 500000;

	typedef enum logic [1:0] {
		STEP_AVAIL,
		STEP_ROW,
		STEP_ROW_TYPED
	} step_kind_e;

	// One entry of the directed table: either a write of all three available
	// registers, or a row transfer with an optional hand-written expectation.
	typedef struct packed {
		step_kind_e            kind;
		row_t                  rw;
		logic [CFG_DATA_W-1:0] av0;
		logic [CFG_DATA_W-1:0] av1;
		logic [CFG_DATA_W-1:0] av2;
		result_t               want;
	} plan_step_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	row_t                  row;
	logic                  busy;
	logic                  result_valid;
	result_t               result;
	logic                  wr_en;
	logic [CFG_ADDR_W-1:0] wr_addr;
	logic [CFG_DATA_W-1:0] wr_data;

	// Mirror of the block's state, kept by the finish order predictor.
	int unsigned        avail_units [NUM_RES];
	logic [FIELD_W-1:0] held_units [PROCESSES][NUM_RES];
	logic [FIELD_W-1:0] need_units [PROCESSES][NUM_RES];
	int                 table_rows = 0;

	// Finish order entries that the block still owes us, oldest first.
	result_t            finish_order_q [$];
	int                 mismatches = 0;
	plan_step_t         directed_plan [$];

	bankers_safety_check #(
		.PROCESSES(PROCESSES),
		.UNIT_BITS(UNIT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.row(row),
		.busy(busy),
		.result_valid(result_valid),
		.result(result),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Runaway guard: far beyond the slowest legal run of this stimulus.
	initial begin
		repeat (TIMEOUT_CYCLES) @(posedge clk);
		$display("bankers_safety_check regression: fail");
		$finish;
	end

	// Stores one row the way the block does and, on a last row, runs the
	// whole safety walk and queues the finish order. Returns how many results
	// were queued. Unit width equals field width here, so no masking is needed.
	function automatic int predict_finish_order(input row_t r);
		logic [FIELD_W-1:0] held [NUM_RES];
		logic [FIELD_W-1:0] claim [NUM_RES];
		int unsigned        work [NUM_RES];
		bit                 done [PROCESSES];
		int                 order [PROCESSES];
		int                 finished;
		int                 n_out;
		bit                 fits;
		result_t            res;

		held[0] = r.alloc_r0;
		held[1] = r.alloc_r1;
		held[2] = r.alloc_r2;
		claim[0] = r.max_r0;
		claim[1] = r.max_r1;
		claim[2] = r.max_r2;

		// Rows past the table size are dropped, but a dropped last row still
		// starts the walk over what is stored.
		if (table_rows < PROCESSES) begin
			for (int i = 0; i < NUM_RES; i++) begin
				held_units[table_rows][i] = held[i];
				need_units[table_rows][i] = (claim[i] > held[i]) ? claim[i] - held[i] : '0;
			end
			table_rows++;
		end
		if (!r.last_row)
			return 0;

		for (int i = 0; i < NUM_RES; i++)
			work[i] = avail_units[i];
		for (int p = 0; p < PROCESSES; p++)
			done[p] = 1'b0;
		finished = 0;

		// Greedy walk: a process that fits finishes on the spot and releases
		// its allocation, so later processes in the same pass see the gain.
		for (int pass = 0; pass < PROCESSES; pass++) begin
			for (int p = 0; p < table_rows; p++) begin
				if (!done[p]) begin
					fits = 1'b1;
					for (int i = 0; i < NUM_RES; i++)
						if (need_units[p][i] > work[i])
							fits = 1'b0;
					if (fits) begin
						for (int i = 0; i < NUM_RES; i++)
							work[i] += held_units[p][i];
						done[p] = 1'b1;
						order[finished] = p;
						finished++;
					end
				end
			end
		end

		if (finished == 0) begin
			// Nothing could finish: a single entry-less verdict.
			res = '{proc_id: '0, entry_valid: 1'b0, safe: 1'b0, last_result: 1'b1};
			finish_order_q.push_back(res);
			n_out = 1;
		end else begin
			n_out = (finished < MAX_OUT) ? finished : MAX_OUT;
			for (int k = 0; k < n_out; k++) begin
				res.proc_id = PID_W'(order[k]);
				res.entry_valid = 1'b1;
				res.safe = (finished == table_rows);
				res.last_result = (k == n_out - 1);
				finish_order_q.push_back(res);
			end
		end
		table_rows = 0;
		return n_out;
	endfunction

	// Offers one row from a falling edge and holds it until the block takes it.
	// Returns at the next falling edge with start still high, so the caller can
	// either offer the next row or drop start without a second assignment.
	task automatic drive_row(input row_t r, input bit typed, input result_t typed_res);
		int      n_queued;
		result_t dropped;

		start = 1'b1;
		row = r;
		do
			@(posedge clk);
		while (busy);
		n_queued = predict_finish_order(r);
		// Where the expected verdict is written in the table, it replaces what
		// the predictor queued for this row.
		if (typed) begin
			repeat (n_queued) dropped = finish_order_q.pop_back();
			finish_order_q.push_back(typed_res);
		end
		@(negedge clk);
	endtask

	// Random sender gap: idles for a geometric number of cycles.
	task automatic sender_gap(input int pct);
		while ($urandom_range(0, 99) < pct) begin
			start = 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
		wr_en = 1'b1;
		wr_addr = addr;
		wr_data = CFG_DATA_W'(value);
		case (addr)
			REG_AVAIL_R0: avail_units[0] = value & 8'hFF;
			REG_AVAIL_R1: avail_units[1] = value & 8'hFF;
			REG_AVAIL_R2: avail_units[2] = value & 8'hFF;
			default: ;
		endcase
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	// Waits until the block owes nothing and has dropped busy, lets it settle,
	// then rewrites the available vector. This is also the sender's pause.
	task automatic load_available(input int v0, input int v1, input int v2);
		start = 1'b0;
		while (finish_order_q.size() != 0 || busy)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(REG_AVAIL_R0, v0);
		write_reg(REG_AVAIL_R1, v1);
		write_reg(REG_AVAIL_R2, v2);
	endtask

	function automatic plan_step_t avail_step(input int v0, input int v1, input int v2);
		plan_step_t s;

		s = '0;
		s.kind = STEP_AVAIL;
		s.av0 = CFG_DATA_W'(v0);
		s.av1 = CFG_DATA_W'(v1);
		s.av2 = CFG_DATA_W'(v2);
		return s;
	endfunction

	function automatic plan_step_t row_step(input int a0, input int a1, input int a2,
			input int m0, input int m1, input int m2, input bit last);
		plan_step_t s;

		s = '0;
		s.kind = STEP_ROW;
		s.rw.alloc_r0 = FIELD_W'(a0);
		s.rw.alloc_r1 = FIELD_W'(a1);
		s.rw.alloc_r2 = FIELD_W'(a2);
		s.rw.max_r0 = FIELD_W'(m0);
		s.rw.max_r1 = FIELD_W'(m1);
		s.rw.max_r2 = FIELD_W'(m2);
		s.rw.last_row = last;
		return s;
	endfunction

	function automatic plan_step_t typed_row(input plan_step_t s, input result_t want);
		plan_step_t t;

		t = s;
		t.kind = STEP_ROW_TYPED;
		t.want = want;
		return t;
	endfunction

	// Random row content. Most rows hold modest allocations and needs, so that
	// against a modest available vector the walk finishes some processes in a
	// shuffled order and stalls on others. The rest is full-range noise and
	// rows whose allocation exceeds their claim.
	function automatic row_t random_row(input bit last);
		row_t r;
		int   mode;
		int   a [NUM_RES];
		int   m [NUM_RES];

		mode = $urandom_range(0, 9);
		for (int i = 0; i < NUM_RES; i++) begin
			if (mode < 2) begin
				a[i] = $urandom_range(0, 255);
				m[i] = $urandom_range(0, 255);
			end else if (mode == 2) begin
				a[i] = $urandom_range(1, 255);
				m[i] = $urandom_range(0, a[i] - 1);
			end else begin
				a[i] = $urandom_range(0, 40);
				m[i] = a[i] + $urandom_range(0, 60);
			end
		end
		r.alloc_r0 = FIELD_W'(a[0]);
		r.alloc_r1 = FIELD_W'(a[1]);
		r.alloc_r2 = FIELD_W'(a[2]);
		r.max_r0 = FIELD_W'(m[0]);
		r.max_r1 = FIELD_W'(m[1]);
		r.max_r2 = FIELD_W'(m[2]);
		r.last_row = last;
		return r;
	endfunction

	function automatic int field_differs(input string name, input int want, input logic [3:0] got);
		if (got !== want[3:0]) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Results cannot be held off, so every strobed cycle is a transfer.
	always @(posedge clk) begin : check_results
		result_t want;
		int      bad;

		if (arst_n && result_valid) begin
			if (finish_order_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, result);
				mismatches++;
			end else begin
				want = finish_order_q.pop_front();
				bad = 0;
				bad += field_differs("proc_id", want.proc_id, 4'(result.proc_id));
				bad += field_differs("entry_valid", want.entry_valid, 4'(result.entry_valid));
				bad += field_differs("safe", want.safe, 4'(result.safe));
				bad += field_differs("last_result", want.last_result, 4'(result.last_result));
				if (bad != 0)
					mismatches++;
			end
		end
	end

	initial begin
		int rows_sent;
		int phase;
		int phase_rows;
		int gap_pct;
		int table_len;
		int v [NUM_RES];

		arst_n = 1'b0;
		start = 1'b0;
		row = '0;
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		for (int i = 0; i < NUM_RES; i++)
			avail_units[i] = 0;

		// Directed table. Single-row checks with an obvious verdict carry it
		// inline; the larger tables are left to the predictor.
		directed_plan.push_back(avail_step(0, 0, 0));
		// Zero need against zero available still finishes.
		directed_plan.push_back(typed_row(row_step(0, 0, 0, 0, 0, 0, 1'b1),
			'{proc_id: 3'd0, entry_valid: 1'b1, safe: 1'b1, last_result: 1'b1}));
		// Nothing can finish: one entry-less unsafe verdict.
		directed_plan.push_back(typed_row(row_step(0, 0, 0, 255, 255, 255, 1'b1),
			'{proc_id: 3'd0, entry_valid: 1'b0, safe: 1'b0, last_result: 1'b1}));
		// Allocation above the claim clamps the need to zero.
		directed_plan.push_back(typed_row(row_step(255, 255, 255, 0, 0, 0, 1'b1),
			'{proc_id: 3'd0, entry_valid: 1'b1, safe: 1'b1, last_result: 1'b1}));
		// Full table finishing out of index order, two processes only on a later pass,
		// and two extra rows are dropped; the dropped last row starts the walk.
		directed_plan.push_back(avail_step(10, 12, 17));
		directed_plan.push_back(row_step(5, 5, 5, 50, 50, 50, 1'b0));
		directed_plan.push_back(row_step(20, 0, 7, 25, 4, 9, 1'b0));
		directed_plan.push_back(row_step(0, 30, 0, 12, 35, 15, 1'b0));
		directed_plan.push_back(row_step(1, 1, 1, 255, 1, 1, 1'b0));
		directed_plan.push_back(row_step(40, 40, 40, 40, 40, 40, 1'b0));
		directed_plan.push_back(row_step(0, 0, 0, 60, 60, 60, 1'b0));
		directed_plan.push_back(row_step(255, 0, 0, 0, 0, 0, 1'b0));
		directed_plan.push_back(row_step(3, 200, 9, 3, 210, 9, 1'b0));
		directed_plan.push_back(row_step(0, 0, 0, 0, 0, 0, 1'b0));
		directed_plan.push_back(row_step(7, 7, 7, 7, 7, 7, 1'b1));
		// Every process fits at once: eight entries, the eighth marked last.
		directed_plan.push_back(avail_step(255, 255, 255));
		for (int k = 0; k < PROCESSES; k++)
			directed_plan.push_back(row_step(k * 36, 255 - k * 36, 17 * k,
				k * 36, 200 - k * 20, 0, k == PROCESSES - 1));
		// One process finishes and the other does not: unsafe with an entry.
		directed_plan.push_back(avail_step(0, 0, 0));
		directed_plan.push_back(row_step(9, 9, 9, 9, 9, 9, 1'b0));
		directed_plan.push_back(row_step(0, 0, 0, 100, 100, 100, 1'b1));

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_plan[i]) begin
			case (directed_plan[i].kind)
				STEP_AVAIL: load_available(directed_plan[i].av0, directed_plan[i].av1,
					directed_plan[i].av2);
				STEP_ROW: drive_row(directed_plan[i].rw, 1'b0, directed_plan[i].want);
				STEP_ROW_TYPED: drive_row(directed_plan[i].rw, 1'b1, directed_plan[i].want);
				default: ;
			endcase
		end

		// Random phases. Each phase sets a fresh available vector while the
		// block is idle and then sends whole tables, mostly of legal size with
		// an occasional overflow, under one sender idling pattern.
		rows_sent = 0;
		phase = 0;
		while (rows_sent < RANDOM_ROWS) begin
			case (phase % 3)
				0: gap_pct = 0;
				1: gap_pct = 85;
				default: gap_pct = 32;
			endcase
			for (int i = 0; i < NUM_RES; i++) begin
				case (phase % 5)
					1: v[i] = 0;
					3: v[i] = 255;
					4: v[i] = $urandom_range(0, 255);
					default: v[i] = $urandom_range(0, 100);
				endcase
			end
			load_available(v[0], v[1], v[2]);

			phase_rows = 0;
			while (phase_rows < PHASE_ROWS && rows_sent < RANDOM_ROWS) begin
				case ($urandom_range(0, 9))
					0: table_len = $urandom_range(PROCESSES + 1, PROCESSES + 3);
					1: table_len = PROCESSES;
					default: table_len = $urandom_range(1, PROCESSES - 1);
				endcase
				for (int k = 0; k < table_len; k++) begin
					sender_gap(gap_pct);
					drive_row(random_row(k == table_len - 1), 1'b0, '0);
					if (k < PROCESSES)
						phase_rows++;
				end
				rows_sent += (table_len < PROCESSES) ? table_len : PROCESSES;
			end
			phase++;
		end

		start = 1'b0;
		while (finish_order_q.size() != 0)
			@(posedge clk);
		// Stray results after the last expected one would show up here.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (finish_order_q.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, finish_order_q.size());
		if (mismatches == 0 && finish_order_q.size() == 0) begin
			$display("bankers_safety_check regression: pass");
		end else begin
			$display("bankers_safety_check regression: fail");
		end
		$finish;
	end

endmodule
